// File: sv/mspl_pkg.sv
package mspl_pkg;

    // Fixed-point and field widths
    localparam int DUTY_MAX       = 1023;
    localparam int DUTY_W         = 10;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int TICK_W         = 16;
    localparam int BUDGET_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int INTEG_W        = 32;
    localparam int IMAX_W         = 31;
    localparam int ERR_W          = TICK_W + 1;
    localparam int SUM_W          = INTEG_W + 1;
    localparam int PROD_W         = GAIN_W + INTEG_W + 1;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_IDX_W      = 2;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_TARGET = 2'd2,
        CMD_EMERG  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_INTEG_MIN  = 2'd2,
        CFG_INTEG_MAX  = 2'd3
    } cfg_idx_t;

    // Drive action decided in the front stage
    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_PI    = 2'd1,
        ACT_BRAKE = 2'd2
    } act_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  prop_gain;
        logic signed [GAIN_W-1:0]  integ_gain;
        logic signed [INTEG_W-1:0] integ_min;
        logic [IMAX_W-1:0]         integ_max;
    } cfg_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic                     second_channel;
        logic signed [TICK_W-1:0] new_target_ticks;
        logic [BUDGET_W-1:0]      new_cycle_budget;
        logic                     brake_request;
    } item_t;

    typedef struct packed {
        act_t                      act;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic [TICK_W-1:0]         measured;
        logic [BUDGET_W-1:0]       cycles;
        logic                      report;
        logic                      braked;
    } mid_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic                dir_pin_a;
        logic                dir_pin_b;
        logic [TICK_W-1:0]   measured;
        logic [BUDGET_W-1:0] cycles;
        logic                report;
        logic                braked;
    } res_t;

endpackage

// File: sv/mspl_item_if.sv
interface mspl_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic              second_channel;
    logic signed [15:0] new_target_ticks;
    logic [15:0]       new_cycle_budget;
    logic              brake_request;

    modport source (
        output valid, cmd, second_channel, new_target_ticks, new_cycle_budget,
               brake_request,
        input  ready
    );
    modport sink (
        input  valid, cmd, second_channel, new_target_ticks, new_cycle_budget,
               brake_request,
        output ready
    );
endinterface

// File: sv/mspl_result_if.sv
interface mspl_result_if;
    logic               valid;
    logic               ready;
    logic [9:0]         duty;
    logic               dir_pin_a;
    logic               dir_pin_b;
    logic signed [15:0] measured_ticks;
    logic [15:0]        cycles_left;
    logic               report_valid;
    logic               braked;

    modport source (
        output valid, duty, dir_pin_a, dir_pin_b, measured_ticks, cycles_left,
               report_valid, braked,
        input  ready
    );
    modport sink (
        input  valid, duty, dir_pin_a, dir_pin_b, measured_ticks, cycles_left,
               report_valid, braked,
        output ready
    );
endinterface

// File: sv/encoder_pi_motor_speed_loop.sv
// Channel   Dir   Role
// item      in    events: encoder edge, control tick, new target, emergency
// result    out   drive state after each event, one transaction per item
// cfg_*     in    gain and integrator clamp register writes
//
// One item enters per cycle while the result is taken; a result is offered after the item passes
// the input register, the error/integrator stage and the gain multiply stage.
// The two 16x32 and 16x17 gain multiplies set the cycle time of the last stage.
// Reset clears all loop state and loads the register defaults.
// A stalled result holds the pipeline; item.ready drops only when all stages
// are full and the result is not taken.
module encoder_pi_motor_speed_loop (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mspl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mspl_pkg::CFG_DATA_W-1:0]       cfg_data,
    mspl_item_if.sink                             item,
    mspl_result_if.source                         result
);
    import mspl_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    mid_t  mid;
    res_t  res;

    logic s0_valid_reg, s1_valid_reg, out_valid_reg;
    logic out_free, s1_free, s0_move, s1_move, accept;

    // Pipeline flow control
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_move    = s1_valid_reg && out_free;
    assign s1_free    = !s1_valid_reg || out_free;
    assign s0_move    = s0_valid_reg && s1_free;
    assign item.ready = !s0_valid_reg || s1_free;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s0_valid_reg <= 1'b1;
            else if (s0_move)
                s0_valid_reg <= 1'b0;
            if (s0_move)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd              <= cmd_t'(item.cmd);
            item_reg.second_channel   <= item.second_channel;
            item_reg.new_target_ticks <= item.new_target_ticks;
            item_reg.new_cycle_budget <= item.new_cycle_budget;
            item_reg.brake_request    <= item.brake_request;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain  <= GAIN_W'(256);
            cfg_reg.integ_gain <= '0;
            cfg_reg.integ_min  <= -INTEG_W'(65536);
            cfg_reg.integ_max  <= IMAX_W'(65536);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: cfg_reg.integ_gain <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_MIN:  cfg_reg.integ_min  <= cfg_data[INTEG_W-1:0];
                CFG_INTEG_MAX:  cfg_reg.integ_max  <= cfg_data[IMAX_W-1:0];
                default:        cfg_reg.integ_max  <= cfg_reg.integ_max;
            endcase
        end
    end

    mspl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .item_d (item_reg),
        .step   (s0_move),
        .cfg    (cfg_reg),
        .mid    (mid)
    );

    mspl_drive u_drive (
        .clk   (clk),
        .rst_n (rst_n),
        .mid   (mid),
        .step  (s1_move),
        .cfg   (cfg_reg),
        .res   (res)
    );

    // Drive the result channel
    assign result.valid          = out_valid_reg;
    assign result.duty           = res.duty;
    assign result.dir_pin_a      = res.dir_pin_a;
    assign result.dir_pin_b      = res.dir_pin_b;
    assign result.measured_ticks = res.measured;
    assign result.cycles_left    = res.cycles;
    assign result.report_valid   = res.report;
    assign result.braked         = res.braked;

endmodule

// File: sv/mspl_front.sv
module mspl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  mspl_pkg::item_t item_d,
    input  logic            step,
    input  mspl_pkg::cfg_t  cfg,
    output mspl_pkg::mid_t  mid
);
    import mspl_pkg::*;

    logic [TICK_W-1:0]         tick_count_reg, tick_count_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [TICK_W-1:0]         target_reg, target_next;
    logic [BUDGET_W-1:0]       budget_reg, budget_next;
    logic                      emerg_reg, emerg_next;
    logic [TICK_W-1:0]         last_meas_reg, last_meas_next;
    mid_t                      mid_reg, mid_next;

    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum_raw, sum_clamp, imin_ext, imax_ext;
    logic                    brake_now;

    // Speed error and clamped integrator sum
    always_comb
    begin
        err       = $signed({target_reg[TICK_W-1], target_reg})
                  - $signed({tick_count_reg[TICK_W-1], tick_count_reg});
        sum_raw   = $signed({integ_reg[INTEG_W-1], integ_reg})
                  + SUM_W'(err);
        imin_ext  = $signed({cfg.integ_min[INTEG_W-1], cfg.integ_min});
        imax_ext  = $signed({2'b00, cfg.integ_max});
        sum_clamp = sum_raw;
        if (sum_clamp < imin_ext)
            sum_clamp = imin_ext;
        if (sum_clamp > imax_ext)
            sum_clamp = imax_ext;
        brake_now = emerg_reg || (budget_reg == '0);
    end

    // Decode the command and update loop state
    always_comb
    begin
        tick_count_next = tick_count_reg;
        integ_next      = integ_reg;
        target_next     = target_reg;
        budget_next     = budget_reg;
        emerg_next      = emerg_reg;
        last_meas_next  = last_meas_reg;
        mid_next.act    = ACT_HOLD;
        unique case (item_d.cmd)
            CMD_EDGE:
            begin
                if (item_d.second_channel)
                    tick_count_next = tick_count_reg + 1'b1;
                else
                    tick_count_next = tick_count_reg - 1'b1;
            end
            CMD_TICK:
            begin
                tick_count_next = '0;
                last_meas_next  = tick_count_reg;
                if (brake_now)
                    mid_next.act = ACT_BRAKE;
                else
                begin
                    mid_next.act = ACT_PI;
                    integ_next   = sum_clamp[INTEG_W-1:0];
                    budget_next  = budget_reg - 1'b1;
                end
            end
            CMD_TARGET:
            begin
                target_next = item_d.new_target_ticks;
                budget_next = item_d.new_cycle_budget;
                integ_next  = '0;
            end
            CMD_EMERG:
            begin
                emerg_next = item_d.brake_request;
                if (item_d.brake_request)
                    mid_next.act = ACT_BRAKE;
            end
            default:
            begin
                mid_next.act = ACT_HOLD;
            end
        endcase
        mid_next.err      = err;
        mid_next.integ    = sum_clamp[INTEG_W-1:0];
        mid_next.measured = last_meas_next;
        mid_next.cycles   = budget_next;
        mid_next.report   = (item_d.cmd == CMD_TICK);
        mid_next.braked   = emerg_next;
    end

    // Hold loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            integ_reg      <= '0;
            target_reg     <= '0;
            budget_reg     <= '0;
            emerg_reg      <= 1'b0;
            last_meas_reg  <= '0;
        end
        else if (step)
        begin
            tick_count_reg <= tick_count_next;
            integ_reg      <= integ_next;
            target_reg     <= target_next;
            budget_reg     <= budget_next;
            emerg_reg      <= emerg_next;
            last_meas_reg  <= last_meas_next;
        end
    end

    // Stage register toward the gain multiply
    always_ff @(posedge clk)
    begin
        if (step)
            mid_reg <= mid_next;
    end

    assign mid = mid_reg;

endmodule

// File: sv/mspl_drive.sv
module mspl_drive (
    input  logic           clk,
    input  logic           rst_n,
    input  mspl_pkg::mid_t mid,
    input  logic           step,
    input  mspl_pkg::cfg_t cfg,
    output mspl_pkg::res_t res
);
    import mspl_pkg::*;

    logic signed [GAIN_W+ERR_W-1:0]   prod_p;
    logic signed [GAIN_W+INTEG_W-1:0] prod_i;
    logic signed [PROD_W-1:0]         gain_sum, shifted;
    logic [PROD_W-1:0]                mag;
    logic [DUTY_W-1:0]                pi_duty;
    logic                             pi_dir;

    logic              dir_reg, dir_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic              braking_reg, braking_next;
    res_t              res_reg, res_next;

    // Gain products, floor shift, magnitude and saturation
    always_comb
    begin
        prod_p   = (GAIN_W+ERR_W)'(cfg.prop_gain) * (GAIN_W+ERR_W)'(mid.err);
        prod_i   = (GAIN_W+INTEG_W)'(cfg.integ_gain) * (GAIN_W+INTEG_W)'(mid.integ);
        gain_sum = PROD_W'(prod_p) + PROD_W'(prod_i);
        shifted  = gain_sum >>> GAIN_FRAC_BITS;
        if (shifted < 0)
        begin
            mag    = PROD_W'(-shifted);
            pi_dir = 1'b0;
        end
        else
        begin
            mag    = PROD_W'(shifted);
            pi_dir = (shifted != 0);
        end
        if (mag > PROD_W'(DUTY_MAX))
            pi_duty = DUTY_W'(DUTY_MAX);
        else
            pi_duty = mag[DUTY_W-1:0];
    end

    // Apply the drive action and form the result
    always_comb
    begin
        dir_next     = dir_reg;
        duty_next    = duty_reg;
        braking_next = braking_reg;
        unique case (mid.act)
            ACT_PI:
            begin
                dir_next     = pi_dir;
                duty_next    = pi_duty;
                braking_next = 1'b0;
            end
            ACT_BRAKE:
            begin
                duty_next    = '0;
                braking_next = 1'b1;
            end
            ACT_HOLD:
            begin
                braking_next = braking_reg;
            end
            default:
            begin
                braking_next = braking_reg;
            end
        endcase
        if (braking_next)
        begin
            res_next.duty      = '0;
            res_next.dir_pin_a = 1'b1;
            res_next.dir_pin_b = 1'b1;
        end
        else
        begin
            res_next.duty      = duty_next;
            res_next.dir_pin_a = dir_next;
            res_next.dir_pin_b = !dir_next;
        end
        res_next.measured = mid.measured;
        res_next.cycles   = mid.cycles;
        res_next.report   = mid.report;
        res_next.braked   = mid.braked;
    end

    // Hold drive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= 1'b0;
            duty_reg    <= '0;
            braking_reg <= 1'b0;
        end
        else if (step)
        begin
            dir_reg     <= dir_next;
            duty_reg    <= duty_next;
            braking_reg <= braking_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// File: dv/mspl_checker.sv
module mspl_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mspl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mspl_pkg::CFG_DATA_W-1:0] cfg_data,
    mspl_item_if                            item_mon,
    mspl_result_if                          result_mon,
    output int                              mismatches,
    output int                              outstanding
);
    import mspl_pkg::*;

    // Register defaults after reset
    localparam logic signed [GAIN_W-1:0]  KP_RESET = 16'sd256;
    localparam logic signed [GAIN_W-1:0]  KI_RESET = 16'sd0;
    localparam logic signed [INTEG_W-1:0] LO_RESET = -32'sd65536;
    localparam logic [IMAX_W-1:0]         HI_RESET = 31'd65536;
    localparam int                        PRINT_CAP = 100;

    // Shadow copy of the loop registers
    logic signed [GAIN_W-1:0]  kp;
    logic signed [GAIN_W-1:0]  ki;
    logic signed [INTEG_W-1:0] clamp_lo;
    logic [IMAX_W-1:0]         clamp_hi;

    // Shadow copy of the loop state
    logic signed [TICK_W-1:0]  tick_acc;
    logic signed [TICK_W-1:0]  target_q;
    logic signed [TICK_W-1:0]  last_ticks;
    logic [BUDGET_W-1:0]       budget_q;
    logic signed [INTEG_W-1:0] err_sum;
    logic [DUTY_W-1:0]         duty_q;
    logic                      estop;
    logic                      fwd;
    logic                      brake_q;

    // Drive states expected on the result channel, oldest first
    res_t drive_q[$];

    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatches < PRINT_CAP)
            $display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the speed loop by one event and return the drive state it shows
    function automatic res_t apply_event(item_t ev);
        res_t               r;
        logic [TICK_W-1:0]  latched;
        longint             err;
        longint             acc;
        longint             mix;
        longint             mag;
        longint             frac_mask;
        r = '0;
        frac_mask = (longint'(1) <<< GAIN_FRAC_BITS) - 1;
        case (ev.cmd)
            CMD_EDGE:
            begin
                if (ev.second_channel)
                    tick_acc = tick_acc + 16'sd1;
                else
                    tick_acc = tick_acc - 16'sd1;
            end
            CMD_TICK:
            begin
                latched = tick_acc;
                tick_acc = '0;
                if (estop || budget_q == '0)
                begin
                    brake_q = 1'b1;
                    duty_q = '0;
                end
                else
                begin
                    err = longint'(target_q) - longint'(signed'(latched));
                    acc = longint'(err_sum) + err;
                    // Clamp up to the floor first, then down to the ceiling
                    if (acc < longint'(clamp_lo))
                        acc = longint'(clamp_lo);
                    if (acc > longint'(clamp_hi))
                        acc = longint'(clamp_hi);
                    err_sum = acc[INTEG_W-1:0];
                    mix = longint'(kp) * err + longint'(ki) * acc;
                    // Floor shift: negative sums round the magnitude up
                    if (mix < 0)
                    begin
                        mag = (-mix + frac_mask) >> GAIN_FRAC_BITS;
                        fwd = 1'b0;
                    end
                    else
                    begin
                        mag = mix >> GAIN_FRAC_BITS;
                        fwd = (mag > 0);
                    end
                    if (mag > DUTY_MAX)
                        mag = DUTY_MAX;
                    duty_q = mag[DUTY_W-1:0];
                    brake_q = 1'b0;
                    budget_q = budget_q - 1'b1;
                end
                last_ticks = latched;
                r.report = 1'b1;
            end
            CMD_TARGET:
            begin
                target_q = ev.new_target_ticks;
                budget_q = ev.new_cycle_budget;
                err_sum = '0;
            end
            default:
            begin
                estop = ev.brake_request;
                if (estop)
                begin
                    brake_q = 1'b1;
                    duty_q = '0;
                end
            end
        endcase
        if (brake_q)
        begin
            r.duty = '0;
            r.dir_pin_a = 1'b1;
            r.dir_pin_b = 1'b1;
        end
        else
        begin
            r.duty = duty_q;
            r.dir_pin_a = fwd;
            r.dir_pin_b = !fwd;
        end
        r.measured = last_ticks;
        r.cycles = budget_q;
        r.braked = estop;
        return r;
    endfunction

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        item_t ev;
        res_t  got;
        res_t  want;
        if (!rst_n)
        begin
            kp = KP_RESET;
            ki = KI_RESET;
            clamp_lo = LO_RESET;
            clamp_hi = HI_RESET;
            tick_acc = '0;
            target_q = '0;
            last_ticks = '0;
            budget_q = '0;
            err_sum = '0;
            duty_q = '0;
            estop = 1'b0;
            fwd = 1'b0;
            brake_q = 1'b0;
            drive_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare a taken result with the oldest expectation
            if (result_mon.valid && result_mon.ready)
            begin
                got.duty = result_mon.duty;
                got.dir_pin_a = result_mon.dir_pin_a;
                got.dir_pin_b = result_mon.dir_pin_b;
                got.measured = result_mon.measured_ticks;
                got.cycles = result_mon.cycles_left;
                got.report = result_mon.report_valid;
                got.braked = result_mon.braked;
                if (drive_q.size() == 0)
                    flag_mismatch("unexpected result, duty", got.duty, 0);
                else
                begin
                    want = drive_q.pop_front();
                    if (got.duty !== want.duty)
                        flag_mismatch("duty", got.duty, want.duty);
                    if (got.dir_pin_a !== want.dir_pin_a)
                        flag_mismatch("dir_pin_a", got.dir_pin_a, want.dir_pin_a);
                    if (got.dir_pin_b !== want.dir_pin_b)
                        flag_mismatch("dir_pin_b", got.dir_pin_b, want.dir_pin_b);
                    if (got.measured !== want.measured)
                        flag_mismatch("measured_ticks", signed'(got.measured),
                                      signed'(want.measured));
                    if (got.cycles !== want.cycles)
                        flag_mismatch("cycles_left", got.cycles, want.cycles);
                    if (got.report !== want.report)
                        flag_mismatch("report_valid", got.report, want.report);
                    if (got.braked !== want.braked)
                        flag_mismatch("braked", got.braked, want.braked);
                end
            end

            // Predict the result of an accepted event
            if (item_mon.valid && item_mon.ready)
            begin
                ev.cmd = cmd_t'(item_mon.cmd);
                ev.second_channel = item_mon.second_channel;
                ev.new_target_ticks = item_mon.new_target_ticks;
                ev.new_cycle_budget = item_mon.new_cycle_budget;
                ev.brake_request = item_mon.brake_request;
                drive_q.push_back(apply_event(ev));
            end

            // Track register writes
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PROP_GAIN:  kp = cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN: ki = cfg_data[GAIN_W-1:0];
                    CFG_INTEG_MIN:  clamp_lo = cfg_data[INTEG_W-1:0];
                    CFG_INTEG_MAX:  clamp_hi = cfg_data[IMAX_W-1:0];
                    default:        ;
                endcase
            end

            outstanding <= drive_q.size();
        end
    end

endmodule

// File: dv/tb.sv
module tb;
    import mspl_pkg::*;

    localparam int EVENT_COUNT  = 1700;
    localparam int PHASES       = 6;
    localparam int CALM_SPAN    = 150;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 12;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  calm;
    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles;
    int                    sink_hold;
    int                    up_bias;

    mspl_item_if   item_ch ();
    mspl_result_if result_ch ();

    encoder_pi_motor_speed_loop u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    mspl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_mon    (item_ch),
        .result_mon  (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side: hold ready low for a drawn number of cycles after each transaction
    initial
    begin
        sink_hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                sink_hold = calm ? 0 : $urandom_range(0, 3);
            if (sink_hold > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_hold--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one event after a drawn gap and hold it until taken
    task automatic send_event(cmd_t c, logic sc, logic [15:0] tgt, logic [15:0] bud,
                              logic brk);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= c;
        item_ch.second_channel <= sc;
        item_ch.new_target_ticks <= tgt;
        item_ch.new_cycle_budget <= bud;
        item_ch.brake_request <= brk;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result is in
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all four loop registers back to back
    task automatic program_loop(logic [31:0] pg, logic [31:0] ig, logic [31:0] lo,
                                logic [31:0] hi);
        cfg_we <= 1'b1;
        cfg_index <= CFG_PROP_GAIN;
        cfg_data <= pg;
        @(posedge clk);
        cfg_index <= CFG_INTEG_GAIN;
        cfg_data <= ig;
        @(posedge clk);
        cfg_index <= CFG_INTEG_MIN;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= CFG_INTEG_MAX;
        cfg_data <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly edges between ticks, with targets and brake events mixed in
    task automatic send_random_event();
        int          pick;
        logic [15:0] tgt;
        logic [15:0] bud;
        logic        sc;
        logic        brk;
        pick = $urandom_range(0, 99);
        tgt = $urandom;
        bud = $urandom;
        sc = $urandom_range(0, 1);
        brk = $urandom_range(0, 1);
        if (pick < 55)
        begin
            sc = ($urandom_range(0, 99) < up_bias);
            send_event(CMD_EDGE, sc, tgt, bud, brk);
        end
        else if (pick < 77)
            send_event(CMD_TICK, sc, tgt, bud, brk);
        else if (pick < 90)
        begin
            if ($urandom_range(0, 3) != 0)
                tgt = 16'($urandom_range(0, 400) - 200);
            if ($urandom_range(0, 4) != 0)
                bud = 16'($urandom_range(0, 24));
            send_event(CMD_TARGET, sc, tgt, bud, brk);
        end
        else
        begin
            brk = ($urandom_range(0, 2) == 0);
            send_event(CMD_EMERG, sc, tgt, bud, brk);
        end
    endtask

    initial
    begin
        int          phase;
        int          n;
        int          lo_i;
        logic [31:0] pg;
        logic [31:0] ig;
        logic [31:0] lo;
        logic [31:0] hi;

        rst_n <= 1'b0;
        calm <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PROP_GAIN;
        cfg_data <= '0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_EDGE;
        item_ch.second_channel <= 1'b0;
        item_ch.new_target_ticks <= '0;
        item_ch.new_cycle_budget <= '0;
        item_ch.brake_request <= 1'b0;
        up_bias = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed run on the reset gains
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // empty budget brakes
        send_event(CMD_EDGE,   1'b0, 16'hffff, 16'hffff, 1'b1); // count wraps below zero
        send_event(CMD_EDGE,   1'b0, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_TARGET, 1'b1, 16'd5,    16'd2,    1'b1);
        send_event(CMD_EDGE,   1'b1, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_EDGE,   1'b1, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_EDGE,   1'b1, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_TICK,   1'b1, 16'hffff, 16'hffff, 1'b1);
        send_event(CMD_EMERG,  1'b0, 16'h0000, 16'h0000, 1'b1); // brake on
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_EMERG,  1'b1, 16'hffff, 16'hffff, 1'b0); // brake off holds drive
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // last budget cycle
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // budget spent
        send_event(CMD_TARGET, 1'b0, 16'h7fff, 16'hffff, 1'b0);
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // duty saturates
        send_event(CMD_TARGET, 1'b0, 16'h8000, 16'h0001, 1'b0);
        send_event(CMD_EDGE,   1'b1, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // reverse, saturated
        send_event(CMD_TARGET, 1'b0, 16'h0000, 16'h0003, 1'b0);
        send_event(CMD_EDGE,   1'b1, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0); // small negative error drives reverse
        send_event(CMD_EDGE,   1'b0, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0);
        send_event(CMD_EMERG,  1'b0, 16'h0000, 16'h0000, 1'b0); // clear while not braked
        send_event(CMD_TICK,   1'b0, 16'h0000, 16'h0000, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    // Moderate gains and clamps
                    pg = 32'($urandom_range(0, 1024) - 512);
                    ig = 32'($urandom_range(0, 128) - 64);
                    lo = 32'(-$urandom_range(0, 5000));
                    hi = 32'($urandom_range(0, 5000));
                end
                1:
                begin
                    pg = 32'h0000_8000;
                    ig = 32'h0000_7fff;
                    lo = 32'h8000_0000;
                    hi = 32'h7fff_ffff;
                end
                2:
                begin
                    pg = 32'h0000_7fff;
                    ig = 32'h0000_8000;
                    lo = 32'h0000_0000;
                    hi = 32'h0000_0000;
                end
                3:
                begin
                    // Floor above ceiling: the ceiling wins
                    lo_i = $urandom_range(1, 5000);
                    pg = 32'($urandom_range(0, 2048) - 1024);
                    ig = 32'($urandom_range(0, 512) - 256);
                    lo = 32'(lo_i);
                    hi = 32'($urandom_range(0, lo_i - 1));
                end
                4:
                begin
                    pg = $urandom;
                    ig = $urandom;
                    lo = $urandom;
                    hi = $urandom;
                end
                default:
                begin
                    pg = 32'd256;
                    ig = 32'd16;
                    lo = 32'hffff_fe0c;
                    hi = 32'h8000_01f4; // top bit is dropped by the 31-bit register
                end
            endcase
            program_loop(pg, ig, lo, hi);
            up_bias = $urandom_range(20, 80);
            for (n = 0; n < EVENT_COUNT / PHASES; n++)
            begin
                if (n % CALM_SPAN == 0)
                    calm <= ($urandom_range(0, 3) == 0);
                if (phase == 2 && n == EVENT_COUNT / PHASES / 2)
                    settle();
                send_random_event();
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
